FILE: sv/heading_from_xy_degrees_unit_macros.svh
// Assertion helpers for the heading unit.
// Every check is clocked on clk and held off while arst_n is low.
`ifndef HEADING_FROM_XY_DEGREES_UNIT_MACROS_SVH
`define HEADING_FROM_XY_DEGREES_UNIT_MACROS_SVH

// Check a property on every rising edge once out of reset.
`define HFXY_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition implies another one on the next edge.
`define HFXY_ASSERT_NEXT(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

FILE: sv/hfxy_pkg.sv
`default_nettype none
package hfxy_pkg;

	localparam int IN_W        = 16;
	localparam int FRAC_W      = 16;
	localparam int OUT_W       = 9;
	localparam int ITERATIONS  = 16;
	localparam int ANGLE_TABLE_LEN = 24;
	localparam int ITER_N      = (ITERATIONS < ANGLE_TABLE_LEN) ? ITERATIONS : ANGLE_TABLE_LEN;

	// x and y in Q.16 with four guard bits for the CORDIC gain and the first turn
	localparam int XY_W = IN_W + FRAC_W + 4;
	// angle in degrees, Q.16, covering +/- (180 + sum of the table)
	localparam int Z_W  = 26;
	// whole degrees before saturation
	localparam int DEG_W = Z_W - FRAC_W + 1;

	localparam logic signed [Z_W-1:0] DEG180_Q = Z_W'(180 * 65536);
	localparam logic signed [Z_W-1:0] DEG90_Q  = Z_W'(90 * 65536);
	localparam logic signed [OUT_W-1:0] DEG_MAX = OUT_W'(180);
	localparam logic signed [OUT_W-1:0] DEG_MIN = -OUT_W'(180);

	// atan(2^-i) in degrees, Q.16, rounded to nearest
	localparam logic signed [Z_W-1:0] ATAN_DEG_Q [ANGLE_TABLE_LEN] = '{
		Z_W'(2949120), Z_W'(1740967), Z_W'(919879), Z_W'(466945),
		Z_W'(234379),  Z_W'(117304),  Z_W'(58666),  Z_W'(29335),
		Z_W'(14668),   Z_W'(7334),    Z_W'(3667),   Z_W'(1833),
		Z_W'(917),     Z_W'(458),     Z_W'(229),    Z_W'(115),
		Z_W'(57),      Z_W'(29),      Z_W'(14),     Z_W'(7),
		Z_W'(4),       Z_W'(2),       Z_W'(1),      Z_W'(0)
	};

endpackage
`default_nettype wire

FILE: sv/heading_from_xy_degrees_unit.sv
// Compass heading unit: takes one magnetometer word (axis_x, axis_y, signed 16-bit) and
// returns heading_deg = atan2(axis_y, axis_x) in whole degrees, -180 .. 180, truncated
// toward zero; a zero vector gives 0, and a vector on an axis gives an exact 0, +/-90 or
// 180. The angle comes from a vectoring CORDIC with a Q.16 degree accumulator, one
// micro-rotation per rotation stage. A new sample is taken every cycle unless the output
// is stalled. The pipe has one stage to fold the vector into the right half-plane, ITER_N
// rotation stages and one stage to truncate and saturate, ITER_N being ITERATIONS capped
// at 24. When the output word is not taken the whole pipe holds, so sample_ready falls
// only while a finished heading waits at the output.
`default_nettype none
`include "heading_from_xy_degrees_unit_macros.svh"
module heading_from_xy_degrees_unit
	import hfxy_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    sample_valid,
	output logic                         sample_ready,
	input  wire logic signed [IN_W-1:0]  axis_x,
	input  wire logic signed [IN_W-1:0]  axis_y,
	output logic                         heading_valid,
	input  wire logic                    heading_ready,
	output logic signed [OUT_W-1:0]      heading_deg
);

	// advance the whole pipe unless the output word is stalled
	logic adv;
	assign adv          = !heading_valid || heading_ready;
	assign sample_ready = adv;

	// stage 1: scale to Q.16, fold the left half-plane and place the y axis exactly
	logic signed [XY_W-1:0] x_ext, y_ext;
	logic signed [XY_W-1:0] x_pre, y_pre;
	logic signed [Z_W-1:0]  z_pre;

	assign x_ext = {{(XY_W-IN_W-FRAC_W){axis_x[IN_W-1]}}, axis_x, {FRAC_W{1'b0}}};
	assign y_ext = {{(XY_W-IN_W-FRAC_W){axis_y[IN_W-1]}}, axis_y, {FRAC_W{1'b0}}};

	always_comb begin
		x_pre = x_ext;
		y_pre = y_ext;
		z_pre = '0;
		if (axis_x == '0) begin
			// on the y axis: zero the vector so every rotation is skipped and z stays exact
			x_pre = '0;
			y_pre = '0;
			if (axis_y > 0) begin
				z_pre = DEG90_Q;
			end else if (axis_y < 0) begin
				z_pre = -DEG90_Q;
			end
		end else if (axis_x < 0) begin
			// turn by 180 degrees, start the angle from the matching side
			x_pre = -x_ext;
			y_pre = -y_ext;
			z_pre = axis_y[IN_W-1] ? -DEG180_Q : DEG180_Q;
		end
	end

	// index k holds the vector after k micro-rotations
	logic                   valid_s [0:ITER_N];
	logic signed [XY_W-1:0] x_s     [0:ITER_N];
	logic signed [XY_W-1:0] y_s     [0:ITER_N];
	logic signed [Z_W-1:0]  z_s     [0:ITER_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (adv) begin
			valid_s[0] <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0] <= x_pre;
			y_s[0] <= y_pre;
			z_s[0] <= z_pre;
		end
	end

	// rotation stages: drive y toward zero, accumulate the angle turned
	for (genvar k = 0; k < ITER_N; k++) begin : g_rot
		logic signed [XY_W-1:0] xs, ys;
		logic signed [XY_W-1:0] x_nx, y_nx;
		logic signed [Z_W-1:0]  z_nx;

		assign xs = x_s[k] >>> k;
		assign ys = y_s[k] >>> k;

		always_comb begin
			x_nx = x_s[k];
			y_nx = y_s[k];
			z_nx = z_s[k];
			if (y_s[k] > 0) begin
				x_nx = x_s[k] + ys;
				y_nx = y_s[k] - xs;
				z_nx = z_s[k] + ATAN_DEG_Q[k];
			end else if (y_s[k] < 0) begin
				x_nx = x_s[k] - ys;
				y_nx = y_s[k] + xs;
				z_nx = z_s[k] - ATAN_DEG_Q[k];
			end
			// y exactly zero: skip the rotation, keep the angle
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (adv) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				x_s[k+1] <= x_nx;
				y_s[k+1] <= y_nx;
				z_s[k+1] <= z_nx;
			end
		end
	end

	// last stage: truncate toward zero, then clamp to +/-180
	logic signed [Z_W-1:0]   z_fin;
	logic        [Z_W-1:0]   z_abs;
	logic [Z_W-FRAC_W-1:0]   mag;
	logic signed [DEG_W-1:0] deg_t;
	logic signed [OUT_W-1:0] deg_sat;

	assign z_fin = z_s[ITER_N];
	assign z_abs = z_fin[Z_W-1] ? Z_W'(-z_fin) : Z_W'(z_fin);
	assign mag   = z_abs[Z_W-1:FRAC_W];

	always_comb begin
		deg_t = z_fin[Z_W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		if (deg_t > DEG_W'(DEG_MAX)) begin
			deg_sat = DEG_MAX;
		end else if (deg_t < DEG_W'(DEG_MIN)) begin
			deg_sat = DEG_MIN;
		end else begin
			deg_sat = deg_t[OUT_W-1:0];
		end
	end

	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s[ITER_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			heading_deg <= deg_sat;
		end
	end

	assign heading_valid = out_valid_q;

	// a heading handed out never leaves the compass range
	`HFXY_ASSERT(a_heading_range, heading_valid |-> (heading_deg >= DEG_MIN && heading_deg <= DEG_MAX), "heading out of range")
	// a sample on the positive y axis starts at exactly +90 degrees with a zero vector
	`HFXY_ASSERT_NEXT(a_pos_y_axis, sample_valid && sample_ready && axis_x == '0 && axis_y > 0, z_s[0] == DEG90_Q && x_s[0] == '0 && y_s[0] == '0, "y axis fold wrong")
	// a sample on the negative x axis starts at exactly 180 degrees
	`HFXY_ASSERT_NEXT(a_neg_x_axis, sample_valid && sample_ready && axis_x < 0 && axis_y == '0, z_s[0] == DEG180_Q && y_s[0] == '0, "left half-plane fold wrong")
	// a stall freezes the last rotation stage
	`HFXY_ASSERT_NEXT(a_stall_hold, !adv, $stable(z_s[ITER_N]) && $stable(valid_s[ITER_N]), "pipe moved during stall")

endmodule
`default_nettype wire
